FILE: rtl/orrb_pkg.sv
// shared types and constants for the overwriting record ring buffer
`timescale 1ns / 1ps
`default_nettype none
package orrb_pkg;

   localparam int BUFFER_DEPTH_DEF = 1024;
   localparam int RECORD_DEPTH_DEF = 256;
   localparam int CAP_W = 11;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_DATA  = 3'd1,
      OP_POP   = 3'd2,
      OP_READ  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_LONG    = 3'd1,
      ST_FULL    = 3'd2,
      ST_NOTHING = 3'd3,
      ST_SEQ     = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [10:0] record_length;
      logic [7:0]  data_byte;
      logic [9:0]  read_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  read_value;
      logic [10:0] bytes_held;
      logic [8:0]  records_held;
      logic [10:0] front_length;
      logic [31:0] broken_count;
   } rsp_type;

   typedef enum logic [1:0] {
      EX_IDLE  = 2'd0,
      EX_FETCH = 2'd1,
      EX_WORK  = 2'd2,
      EX_SHOW  = 2'd3
   } exec_state_type;

endpackage
`default_nettype wire

FILE: rtl/orrb_queue.sv
// small request queue between front and back parts
`timescale 1ns / 1ps
`default_nettype none
module orrb_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire orrb_pkg::req_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output orrb_pkg::req_type      out_data
);
   import orrb_pkg::*;

   req_type    slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'(QUEUE_DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_data;
   end
endmodule
`default_nettype wire

FILE: rtl/orrb_exec.sv
// back part: executes one transaction against the byte and record memories
`timescale 1ns / 1ps
`default_nettype none
module orrb_exec #(
   parameter int BUFFER_DEPTH = orrb_pkg::BUFFER_DEPTH_DEF,
   parameter int RECORD_DEPTH = orrb_pkg::RECORD_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [10:0]       csr_write_data,
   input  wire logic              q_valid,
   output logic                   q_ready,
   input  wire orrb_pkg::req_type q_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output orrb_pkg::rsp_type      rsp_data
);
   import orrb_pkg::*;

   localparam int BW = $clog2(BUFFER_DEPTH);
   localparam int RW = $clog2(RECORD_DEPTH);
   localparam int RCW = $clog2(RECORD_DEPTH + 1);
   localparam int LW = 17; // holds any capacity length

   // record entry: start index and length
   logic [BW-1:0] rec_start_mem [RECORD_DEPTH];
   logic [LW-1:0] rec_len_mem   [RECORD_DEPTH];
   logic [7:0]    byte_mem      [BUFFER_DEPTH];

   exec_state_type state_ff, state_in;
   req_type        req_ff;
   rsp_type        rsp_ff, rsp_in;

   logic [LW-1:0]  capacity_ff;
   logic [BW-1:0]  head_ff, tail_ff;
   logic [LW-1:0]  bcount_ff, pending_ff;
   logic [RW-1:0]  rhead_ff, rtail_ff;
   logic [RCW-1:0] rcount_ff;
   logic [31:0]    broken_ff;
   logic           counted_ff;

   // registered head record read, plus the length of the entry after it
   logic [BW-1:0]  hstart_ff;
   logic [LW-1:0]  hlen_ff;
   logic [LW-1:0]  hnext_len_ff;
   logic [7:0]     rbyte_ff;

   logic [LW-1:0]  cap_clip;
   logic [LW:0]    sum_tmp;

   function automatic logic [BW-1:0] wrap(input logic [LW:0] v, input logic [LW-1:0] c);
      logic [LW:0] r;
      begin
         r = (v >= {1'b0, c}) ? v - {1'b0, c} : v;
         return r[BW-1:0];
      end
   endfunction

   function automatic logic [RW-1:0] rnext(input logic [RW-1:0] v);
      begin
         return ({1'b0, v} + 1'b1 >= (RW+1)'(RECORD_DEPTH)) ? '0 : v + 1'b1;
      end
   endfunction

   always_comb begin
      cap_clip = LW'(csr_write_data);
      if (cap_clip < LW'(1)) cap_clip = LW'(1);
      if (cap_clip > LW'(BUFFER_DEPTH)) cap_clip = LW'(BUFFER_DEPTH);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EX_IDLE:  if (q_valid) state_in = EX_FETCH;
         EX_FETCH: state_in = EX_WORK;
         EX_WORK:  state_in = EX_SHOW;
         EX_SHOW:  if (rsp_ready) state_in = EX_IDLE;
         default:  state_in = EX_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_ready   = (state_ff == EX_IDLE);
      rsp_valid = (state_ff == EX_SHOW);
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= EX_IDLE;
      else state_ff <= state_in;
   end

   // memory read ports: head record entry, the entry after it and a byte
   logic [LW:0]   rd_sum;
   logic [BW-1:0] rd_addr;
   always_comb begin
      rd_sum  = {1'b0, LW'(hstart_ff)} + (LW+1)'(req_ff.read_offset);
      rd_addr = wrap(rd_sum, capacity_ff);
   end

   always_ff @(posedge clock) begin
      hstart_ff    <= rec_start_mem[rhead_ff];
      hlen_ff      <= rec_len_mem[rhead_ff];
      hnext_len_ff <= rec_len_mem[rnext(rhead_ff)];
      rbyte_ff     <= byte_mem[rd_addr];
      if (state_ff == EX_IDLE && q_valid) req_ff <= q_data;
   end

   // work step: state updates happen in EX_WORK or on a capacity write
   logic           do_drop, last_drop;
   logic [LW-1:0]  nlen;
   logic [LW-1:0]  pop_len;
   logic [BW-1:0]  nhead;
   logic [LW-1:0]  n_bcount;
   logic [RCW-1:0] n_rcount;
   logic [BW-1:0]  n_head;
   logic [RW-1:0]  n_rhead;
   logic [31:0]    n_broken;
   logic           n_counted;
   logic [2:0]     st;
   logic [7:0]     val;
   logic           front_pend;

   always_comb begin
      do_drop   = 1'b0;
      last_drop = 1'b0;
      nhead     = wrap({1'b0, LW'(head_ff)} + 1'b1, capacity_ff);
      nlen      = (hlen_ff != '0) ? hlen_ff - 1'b1 : hlen_ff;
      pop_len   = (hlen_ff > bcount_ff) ? bcount_ff : hlen_ff;
      n_bcount  = bcount_ff;
      n_rcount  = rcount_ff;
      n_head    = head_ff;
      n_rhead   = rhead_ff;
      n_broken  = broken_ff;
      n_counted = counted_ff;
      st        = ST_OK;
      val       = 8'd0;
      front_pend = (rcount_ff == RCW'(1)) && (pending_ff != '0);
      sum_tmp   = '0;
      case (req_ff.operation)
         OP_START: begin
            if (pending_ff != '0) st = ST_SEQ;
            else if (LW'(req_ff.record_length) > capacity_ff) st = ST_LONG;
            else if (req_ff.record_length == '0) st = ST_NOTHING;
            else if (rcount_ff >= RCW'(RECORD_DEPTH)) st = ST_FULL;
            else n_rcount = rcount_ff + 1'b1;
         end
         OP_DATA: begin
            if (pending_ff == '0) st = ST_SEQ;
            else begin
               n_bcount = bcount_ff + 1'b1;
               if (bcount_ff >= capacity_ff && bcount_ff != '0) begin
                  n_head   = nhead;
                  n_bcount = bcount_ff;
                  if (rcount_ff != '0) begin
                     do_drop = 1'b1;
                     if (!counted_ff) begin
                        if (broken_ff != 32'hFFFF_FFFF) n_broken = broken_ff + 1'b1;
                        n_counted = 1'b1;
                     end
                     if (nlen == '0) begin
                        last_drop = 1'b1;
                        n_rhead   = rnext(rhead_ff);
                        n_rcount  = rcount_ff - 1'b1;
                        n_counted = 1'b0;
                     end
                  end
               end
            end
         end
         OP_POP: begin
            if (rcount_ff == '0) st = ST_NOTHING;
            else if (pending_ff != '0) st = ST_SEQ;
            else begin
               sum_tmp   = {1'b0, LW'(head_ff)} + {1'b0, pop_len};
               n_head    = wrap(sum_tmp, capacity_ff);
               n_bcount  = bcount_ff - pop_len;
               n_rhead   = rnext(rhead_ff);
               n_rcount  = rcount_ff - 1'b1;
               n_counted = 1'b0;
            end
         end
         OP_READ: begin
            if (rcount_ff == '0) st = ST_NOTHING;
            else if (front_pend) st = ST_SEQ;
            else if (LW'(req_ff.read_offset) >= hlen_ff) st = ST_NOTHING;
            else val = rbyte_ff;
         end
         OP_CLEAR: begin
            n_bcount  = '0;
            n_rcount  = '0;
            n_head    = '0;
            n_rhead   = '0;
            n_counted = 1'b0;
         end
         default: st = ST_NOTHING;
      endcase
   end

   // front length for the response: the head entry may change this step
   logic [LW-1:0] flen;
   always_comb begin
      flen = hlen_ff;
      if (do_drop && !last_drop) flen = nlen;
      // head moved on: the entry after it becomes the front
      if (n_rhead != rhead_ff) flen = hnext_len_ff;
      // starting into an empty table: the new record becomes the front
      if (req_ff.operation == OP_START && st == ST_OK && rcount_ff == '0)
         flen = LW'(req_ff.record_length);
      if (n_bcount == '0 || n_rcount == '0) flen = '0;
      rsp_in.status       = st;
      rsp_in.read_value   = val;
      rsp_in.bytes_held   = 11'(n_bcount);
      rsp_in.records_held = 9'(n_rcount);
      rsp_in.front_length = 11'(flen);
      rsp_in.broken_count = n_broken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= LW'(BUFFER_DEPTH);
         head_ff     <= '0;
         tail_ff     <= '0;
         bcount_ff   <= '0;
         pending_ff  <= '0;
         rhead_ff    <= '0;
         rtail_ff    <= '0;
         rcount_ff   <= '0;
         broken_ff   <= '0;
         counted_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         capacity_ff <= cap_clip;
         head_ff     <= '0;
         tail_ff     <= '0;
         bcount_ff   <= '0;
         pending_ff  <= '0;
         rhead_ff    <= '0;
         rtail_ff    <= '0;
         rcount_ff   <= '0;
         counted_ff  <= 1'b0;
      end else if (state_ff == EX_WORK) begin
         head_ff     <= n_head;
         bcount_ff   <= n_bcount;
         rhead_ff    <= n_rhead;
         rcount_ff   <= n_rcount;
         broken_ff   <= n_broken;
         counted_ff  <= n_counted;
         case (req_ff.operation)
            OP_START: if (st == ST_OK) begin
               rtail_ff   <= rnext(rtail_ff);
               pending_ff <= LW'(req_ff.record_length);
            end
            OP_DATA: if (st == ST_OK) begin
               tail_ff    <= wrap({1'b0, LW'(tail_ff)} + 1'b1, capacity_ff);
               pending_ff <= pending_ff - 1'b1;
            end
            OP_CLEAR: begin
               tail_ff    <= '0;
               rtail_ff   <= '0;
               pending_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (state_ff == EX_WORK) rsp_ff <= rsp_in;
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (state_ff == EX_WORK) begin
         if (req_ff.operation == OP_START && st == ST_OK) begin
            rec_start_mem[rtail_ff] <= tail_ff;
            rec_len_mem[rtail_ff]   <= LW'(req_ff.record_length);
         end else if (do_drop && !last_drop) begin
            rec_start_mem[rhead_ff] <= nhead;
            rec_len_mem[rhead_ff]   <= nlen;
         end
         if (req_ff.operation == OP_DATA && st == ST_OK) byte_mem[tail_ff] <= req_ff.data_byte;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/overwriting_record_ring_buffer.sv
// top level of the overwriting record ring buffer
`timescale 1ns / 1ps
`default_nettype none
//  channel  | direction | ports
//  request  | in        | req_valid, req_ready, req_data
//  response | out       | rsp_valid, rsp_ready, rsp_data
//  control  | in        | csr_write_enable, csr_write_data (capacity)
//
//  each transaction steps through taking from the queue, a registered memory read,
//  the update, then showing the response until rsp_ready is high; the registered
//  reads come before the read-modify-write of the memories
//  synchronous reset clears all pointers and counters; memories are not cleared
//  a two-entry queue lets requests be taken while a response waits on rsp_ready
module overwriting_record_ring_buffer #(
   parameter int BUFFER_DEPTH = orrb_pkg::BUFFER_DEPTH_DEF,
   parameter int RECORD_DEPTH = orrb_pkg::RECORD_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire orrb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output orrb_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [10:0]       csr_write_data
);
   import orrb_pkg::*;

   // front to back queue
   logic    q_valid, q_ready;
   req_type q_data;

   orrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   // execute unit holds all buffer state
   orrb_exec #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .RECORD_DEPTH (RECORD_DEPTH)
   ) u_exec (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_data           (q_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );
endmodule
`default_nettype wire
